FILE: src/pvt_c2t_pkg.sv
`default_nettype none

package pvt_c2t_pkg;

   // field widths
   localparam int CODE_W = 10;
   localparam int OUT_W  = 19;

   // magnitude of one polynomial term while it is being scaled
   localparam int MAG_W = 19;

   // terms with degree one and up, index 0 holds the fourth-degree term
   localparam int LANE_COUNT = 4;

   // magnitude times code
   localparam int PROD_W = MAG_W + CODE_W;

   // divide by 1000 as multiply by ceil(2^39 / 1000) and shift by 39,
   // exact for every product below 2^29
   localparam int RECIP_W     = 30;
   localparam int RECIP_SHIFT = 39;
   localparam int WIDE_W      = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 30'd549755814;

   // width of the signed sum of all terms
   localparam int SUM_W = 22;

   // coefficient magnitudes, lane i has degree LANE_COUNT - i
   localparam logic [LANE_COUNT-1:0][MAG_W-1:0] COEF_MAG = {
      19'd328430, 19'd185010, 19'd80705, 19'd18439
   };

   // lanes whose coefficient is negative
   localparam logic [LANE_COUNT-1:0] COEF_NEG = 4'b0101;

   // degree zero term
   localparam logic signed [SUM_W-1:0] COEF_CONST = -22'sd48690;

   // range the converted temperature can reach
   localparam logic signed [OUT_W-1:0] TEMP_LOW  = -19'sd48690;
   localparam logic signed [OUT_W-1:0] TEMP_HIGH = 19'sd160000;

   typedef logic [LANE_COUNT-1:0][MAG_W-1:0] pvt_c2t_mag_vec_type;

   // control that travels with each pipeline stage
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } pvt_c2t_ctl_type;

endpackage

`default_nettype wire

FILE: src/pvt_c2t_scale.sv
`default_nettype none

module pvt_c2t_scale
   import pvt_c2t_pkg::*;
#(
   parameter int LANES = LANE_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  pvt_c2t_ctl_type     ctl_in,
   input  pvt_c2t_mag_vec_type mag_in,
   output pvt_c2t_ctl_type     ctl_out,
   output pvt_c2t_mag_vec_type mag_out
);

   pvt_c2t_ctl_type ctl_a_ff;
   pvt_c2t_ctl_type ctl_b_ff;

   // control follows the data through both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
         ctl_b_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      if (i < LANES) begin : g_scale
         logic [PROD_W-1:0] prod_ff;
         logic [PROD_W-1:0] prod_in;
         logic [WIDE_W-1:0] wide;
         logic [MAG_W-1:0]  quot_ff;
         logic [MAG_W-1:0]  quot_in;

         // magnitude times code, then divide by 1000 through the reciprocal
         assign prod_in = PROD_W'(mag_in[i]) * PROD_W'(ctl_in.code);
         assign wide    = WIDE_W'(prod_ff) * WIDE_W'(RECIP);
         assign quot_in = wide[RECIP_SHIFT +: MAG_W];

         always_ff @(posedge clock) begin
            if (en) begin
               prod_ff <= prod_in;
               quot_ff <= quot_in;
            end
         end

         assign mag_out[i] = quot_ff;
      end else begin : g_pass
         logic [MAG_W-1:0] mag_a_ff;
         logic [MAG_W-1:0] mag_b_ff;

         // term already at its degree, delay to stay aligned
         always_ff @(posedge clock) begin
            if (en) begin
               mag_a_ff <= mag_in[i];
               mag_b_ff <= mag_a_ff;
            end
         end

         assign mag_out[i] = mag_b_ff;
      end
   end

   assign ctl_out = ctl_b_ff;

endmodule

`default_nettype wire

FILE: src/pvt_c2t_sum.sv
`default_nettype none

module pvt_c2t_sum
   import pvt_c2t_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  pvt_c2t_ctl_type         ctl_in,
   input  pvt_c2t_mag_vec_type     mag_in,
   output pvt_c2t_ctl_type         ctl_out,
   output logic signed [OUT_W-1:0] temp_out
);

   localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) <<< (OUT_W - 1));
   localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);

   logic signed [SUM_W-1:0] term [LANE_COUNT];
   logic signed [SUM_W-1:0] half_a_ff;
   logic signed [SUM_W-1:0] half_a_in;
   logic signed [SUM_W-1:0] half_b_ff;
   logic signed [SUM_W-1:0] half_b_in;
   logic signed [SUM_W-1:0] total;
   logic signed [OUT_W-1:0] temp_ff;
   logic signed [OUT_W-1:0] temp_in;
   pvt_c2t_ctl_type         ctl_a_ff;
   pvt_c2t_ctl_type         ctl_b_ff;

   // apply the fixed sign of each coefficient
   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         term[i] = COEF_NEG[i] ? -$signed(SUM_W'(mag_in[i])) : $signed(SUM_W'(mag_in[i]));
      end
   end

   // first stage: two partial sums, constant term folded in
   assign half_a_in = term[0] + term[1];
   assign half_b_in = term[2] + term[3] + COEF_CONST;

   // second stage: final sum and clamp to the output range
   assign total = half_a_ff + half_b_ff;

   always_comb begin
      if (total < OUT_MIN) begin
         temp_in = OUT_MIN[OUT_W-1:0];
      end else if (total > OUT_MAX) begin
         temp_in = OUT_MAX[OUT_W-1:0];
      end else begin
         temp_in = total[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
         ctl_b_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         half_a_ff <= half_a_in;
         half_b_ff <= half_b_in;
         temp_ff   <= temp_in;
      end
   end

   assign ctl_out  = ctl_b_ff;
   assign temp_out = temp_ff;

   // code zero gives exactly the constant term
   a_zero_code: assert property (@(posedge clock) disable iff (reset)
      ctl_b_ff.valid && (ctl_b_ff.code == '0) |-> temp_ff == COEF_CONST[OUT_W-1:0])
      else $error("code zero did not give the constant term");

   // result stays within the curve's range
   a_range: assert property (@(posedge clock) disable iff (reset)
      ctl_b_ff.valid |-> (temp_ff >= TEMP_LOW) && (temp_ff <= TEMP_HIGH))
      else $error("temperature outside the curve range");

   // a stalled result holds until the pipeline advances
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ctl_b_ff.valid && !en |=> ctl_b_ff.valid && $stable(temp_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: src/pvt_code_to_temperature.sv
`default_nettype none

// Converts a 10-bit sensor code to milli-degrees Celsius through a fixed
// fourth-degree polynomial in which each term is scaled by code/1000 once per
// degree, truncating toward zero at every step. The block takes one code per
// cycle unless the result side stalls, and passes it through four scaling
// steps of two register stages each (code multiply, then divide by 1000 through
// a reciprocal multiply) followed by two adder stages. When the result side
// stalls, the whole pipeline holds, so req_ready follows !rsp_valid || rsp_ready.

module pvt_code_to_temperature
   import pvt_c2t_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CODE_W-1:0]       req_raw_code,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_temp_millideg
);

   pvt_c2t_ctl_type     ctl_chain [LANE_COUNT+1];
   pvt_c2t_mag_vec_type mag_chain [LANE_COUNT+1];
   pvt_c2t_ctl_type     ctl_last;
   logic                en;

   // pipeline advances unless the output holds an untaken result
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign ctl_chain[0].valid = req_valid;
   assign ctl_chain[0].code  = req_raw_code;
   assign mag_chain[0]       = COEF_MAG;

   // step s scales every term whose degree is above s
   for (genvar s = 0; s < LANE_COUNT; s++) begin : g_step
      pvt_c2t_scale #(
         .LANES (LANE_COUNT - s)
      ) u_scale (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl_chain[s]),
         .mag_in  (mag_chain[s]),
         .ctl_out (ctl_chain[s+1]),
         .mag_out (mag_chain[s+1])
      );
   end

   pvt_c2t_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (ctl_chain[LANE_COUNT]),
      .mag_in   (mag_chain[LANE_COUNT]),
      .ctl_out  (ctl_last),
      .temp_out (rsp_temp_millideg)
   );

   assign rsp_valid = ctl_last.valid;

endmodule

`default_nettype wire

FILE: dv/pvt_temp_checker.sv
`timescale 1ns / 100ps

module pvt_temp_checker
   import pvt_c2t_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [CODE_W-1:0]       req_raw_code,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [OUT_W-1:0] rsp_temp_millideg,
   output int                      mismatch_count,
   output int                      pending_temps
);

   localparam longint SCALE_DIV   = 1000;
   localparam longint TEMP_FLOOR  = -262144;
   localparam longint TEMP_CEIL   = 262143;
   localparam int     REPORT_MAX  = 10;
   localparam int     TERM_COUNT  = 5;

   // temperatures still owed by the block, oldest first
   logic signed [OUT_W-1:0] owed_temps[$];

   // polynomial in code/1000, each scaling truncated toward zero
   function automatic logic signed [OUT_W-1:0] code_to_millideg(
      input logic [CODE_W-1:0] code
   );
      longint      coef [TERM_COUNT]   = '{-18439, 80705, -185010, 328430, -48690};
      int unsigned degree [TERM_COUNT] = '{4, 3, 2, 1, 0};
      longint      scale;
      longint      term;
      longint      sum;
      scale = longint'(code);
      sum   = 0;
      for (int i = 0; i < TERM_COUNT; i++) begin
         term = coef[i];
         for (int d = 0; d < degree[i]; d++)
            term = (term / SCALE_DIV) * scale + ((term % SCALE_DIV) * scale) / SCALE_DIV;
         sum += term;
      end
      // clamp to the output width
      if (sum < TEMP_FLOOR) sum = TEMP_FLOOR;
      if (sum > TEMP_CEIL)  sum = TEMP_CEIL;
      return sum[OUT_W-1:0];
   endfunction

   // watch both channels and compare each result transfer
   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (reset) begin
         owed_temps.delete();
      end else begin
         if (req_valid && req_ready)
            owed_temps.push_back(code_to_millideg(req_raw_code));
         if (rsp_valid && rsp_ready) begin
            if (owed_temps.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("%0t: result transfer with none owed, temp_millideg %0d",
                           $realtime, rsp_temp_millideg);
               mismatch_count++;
            end else begin
               want = owed_temps.pop_front();
               if (rsp_temp_millideg !== want) begin
                  if (mismatch_count < REPORT_MAX)
                     $display("%0t: temp_millideg mismatch, expected %0d actual %0d",
                              $realtime, want, rsp_temp_millideg);
                  mismatch_count++;
               end
            end
         end
      end
      pending_temps = owed_temps.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench
   import pvt_c2t_pkg::*;
();

   localparam int RANDOM_CODES  = 930;
   localparam int CALM_TAIL     = 150;
   localparam int DRAIN_CYCLES  = 20;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CODE_W-1:0]       req_raw_code;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [OUT_W-1:0] rsp_temp_millideg;
   int                      mismatch_count;
   int                      pending_temps;
   bit                      idle_enable;

   pvt_code_to_temperature u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_code      (req_raw_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_temp_millideg (rsp_temp_millideg)
   );

   pvt_temp_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_code      (req_raw_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_temp_millideg (rsp_temp_millideg),
      .mismatch_count    (mismatch_count),
      .pending_temps     (pending_temps)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #2ms;
      $display("testbench: done, errors");
      $finish;
   end

   // one code transfer, valid held until accepted
   task automatic send_code(input logic [CODE_W-1:0] code);
      req_valid    <= 1'b1;
      req_raw_code <= code;
      do @(posedge clock); while (!req_ready);
   endtask

   // occasional random sender gap while idle_enable is set
   task automatic maybe_pause();
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // result side stalls in bursts
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [CODE_W-1:0] code;
      int                pick;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_raw_code <= '0;
      idle_enable  = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range ends, walking ones, around the divisor, plus mid-range codes
      send_code(10'd0);
      send_code(10'd1023);
      for (int b = 0; b < CODE_W; b++) begin
         send_code(CODE_W'(1) << b);
         maybe_pause();
      end
      send_code(10'd1022);
      send_code(10'd999);
      send_code(10'd1000);
      send_code(10'd1001);
      send_code(10'd341);
      send_code(10'd682);
      send_code(10'd500);

      // hold off until every owed result is back
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_temps != 0) @(posedge clock);

      // random codes, mostly uniform with some near the ends
      for (int n = 0; n < RANDOM_CODES; n++) begin
         if (n == RANDOM_CODES - CALM_TAIL)
            idle_enable = 1'b0;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            code = CODE_W'($urandom_range(0, 15));
         else if (pick == 1)
            code = CODE_W'($urandom_range(1008, 1023));
         else
            code = CODE_W'($urandom_range(0, 1023));
         send_code(code);
         if (n == RANDOM_CODES / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_temps != 0) @(posedge clock);
         end else begin
            maybe_pause();
         end
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (pending_temps != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_temps == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
